### sv/site_inbreeding_em_step_core_defines.svh
// Assertion macros for the inbreeding EM step block.
// Used by the checker; expects clk and rst_n in scope.
`ifndef SITE_INBREEDING_EM_STEP_CORE_DEFINES_SVH
`define SITE_INBREEDING_EM_STEP_CORE_DEFINES_SVH

// Same-cycle implication
`define SIE_ASSERT_NOW(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (a) |-> (c)) else $error("assertion failed");

// Next-cycle implication
`define SIE_ASSERT_NEXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (a) |=> (c)) else $error("assertion failed");

`endif

### sv/sie_pkg.sv
// Package for the inbreeding EM step block: constants, step codes,
// controller/datapath structs, rounding helpers and a saturating add. No dependencies.
`default_nettype none
package sie_pkg;

    localparam int ProbW   = 16;
    localparam int CoefW   = 16;
    localparam int AccW    = 40;
    localparam int DivNumW = 55;
    localparam int DivNarrowN = 17;

    localparam logic [16:0] PROB_ONE  = 17'd65536;
    localparam logic [16:0] PRIOR_FLOOR = 17'd7;
    localparam logic [39:0] ACC_MAX   = {40{1'b1}};

    // genotype codes
    localparam logic [1:0] GT_HOM_REF = 2'd0;
    localparam logic [1:0] GT_HET     = 2'd1;
    localparam logic [1:0] GT_HOM_ALT = 2'd2;
    localparam logic [1:0] GT_MISSING = 2'd3;

    // controller step codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PQ    = 4'd1;
    localparam logic [3:0] ST_ADJ   = 4'd2;
    localparam logic [3:0] ST_QQ    = 4'd3;
    localparam logic [3:0] ST_PP    = 4'd4;
    localparam logic [3:0] ST_PR1   = 4'd5;
    localparam logic [3:0] ST_FLOOR = 4'd6;
    localparam logic [3:0] ST_NDIV  = 4'd7;
    localparam logic [3:0] ST_NWAIT = 4'd8;
    localparam logic [3:0] ST_NMUL  = 4'd9;
    localparam logic [3:0] ST_PSUM  = 4'd10;
    localparam logic [3:0] ST_ACC   = 4'd11;
    localparam logic [3:0] ST_FIN   = 4'd12;
    localparam logic [3:0] ST_FWAIT = 4'd13;
    localparam logic [3:0] ST_OUT   = 4'd14;

    // divider operand select
    localparam logic [1:0] SEL_OBS = 2'd3;

    typedef struct packed {
        logic [3:0] step;
        logic [1:0] sel;
        logic       accept;
    } sie_cmd_t;

    typedef struct packed {
        logic div_done;
        logic mode;
        logic pp_zero;
        logic exp_zero;
        logic last;
        logic out_free;
    } sie_status_t;

    // unsigned round half up, drop 16 fraction bits
    function automatic logic [17:0] rnd16(input logic [33:0] v);
        logic [34:0] t;
        t = {1'b0, v} + 35'd32768;
        return t[33:16];
    endfunction

    // signed round half away from zero, drop 14 fraction bits
    function automatic logic signed [20:0] rnd_s14(input logic signed [33:0] v);
        logic [33:0] mag;
        logic [34:0] t;
        logic [20:0] r;
        mag = v[33] ? 34'(-v) : 34'(v);
        t = {1'b0, mag} + 35'd8192;
        r = t[34:14];
        return v[33] ? -$signed(r) : $signed(r);
    endfunction

    // saturating accumulator add
    function automatic logic [39:0] sat_add(input logic [39:0] a, input logic [39:0] b);
        logic [40:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[40] ? ACC_MAX : s[39:0];
    endfunction

endpackage
`default_nettype wire

### sv/sie_if.sv
// Valid/ready channel interfaces for samples in and results out.
// No dependencies.
`default_nettype none
interface sie_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] allele_freq;
    logic [1:0]  genotype_code;
    logic [15:0] lik_hom_ref;
    logic [15:0] lik_het;
    logic signed [15:0] coef_old;
    logic        last_sample;

    modport source (output valid, allele_freq, genotype_code, lik_hom_ref, lik_het,
                    coef_old, last_sample, input ready);
    modport sink (input valid, allele_freq, genotype_code, lik_hom_ref, lik_het,
                  coef_old, last_sample, output ready);
endinterface

interface sie_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] coef_new;
    logic signed [16:0] coef_change;
    logic        missing_error;

    modport source (output valid, coef_new, coef_change, missing_error, input ready);
    modport sink (input valid, coef_new, coef_change, missing_error, output ready);
endinterface
`default_nettype wire

### sv/site_inbreeding_em_step_core.sv
// Top level of the inbreeding coefficient EM step.
// Channels: samples (sie_in_if sink) take one sample per item; results
// (sie_out_if source) give one item per site, on the sample marked last.
// cfg_we/cfg_wdata write input_mode (0 hard genotypes, 1 likelihoods);
// write it only while the block is idle.
// Timing: samples.ready is high only in the idle state. In likelihood
// mode a sample runs up to four 17-step divisions on the shared
// one-bit-per-cycle divider (three when all posteriors are zero);
// genotype mode runs none. A last sample adds the final 55-step
// division, which is skipped when the expected sum is zero.
// Results sit in an output register; the next sample is taken while a
// result waits. If the receiver stalls with a result still held, the
// block holds the following result in its final step until it is free.
// Reset clears the mode, both sums, the error flag and the output valid.
// Depends on sie_pkg, sie_if, sie_ctrl, sie_dp, sie_div.
`default_nettype none
module site_inbreeding_em_step_core (
    input  wire logic clk,
    input  wire logic rst_n,
    sie_in_if.sink    samples,
    sie_out_if.source results,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata
);
    import sie_pkg::*;

    sie_cmd_t    cmd;
    sie_status_t status;

    sie_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    sie_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .allele_freq   (samples.allele_freq),
        .genotype_code (samples.genotype_code),
        .lik_hom_ref   (samples.lik_hom_ref),
        .lik_het       (samples.lik_het),
        .coef_old      (samples.coef_old),
        .last_sample   (samples.last_sample),
        .out_valid     (results.valid),
        .out_ready     (results.ready),
        .coef_new      (results.coef_new),
        .coef_change   (results.coef_change),
        .missing_error (results.missing_error)
    );
endmodule
`default_nettype wire

### sv/sie_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on sie_pkg.
`default_nettype none
module sie_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        wide,
    input  wire logic [54:0] num,
    input  wire logic [39:0] den,
    output logic             done,
    output logic [54:0]      quo
);
    import sie_pkg::*;

    logic [39:0] rem_reg, rem_next;
    logic [54:0] num_reg, num_next;
    logic [39:0] den_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [40:0] trial;
    logic [40:0] diff;

    // one restoring step
    always_comb
    begin
        trial = {rem_reg, num_reg[54]};
        diff  = trial - {1'b0, den_reg};
        rem_next  = rem_reg;
        num_next  = num_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // narrow: high bits preload the remainder, low bits go to the top
            if (wide)
            begin
                rem_next = '0;
                num_next = num;
                cnt_next = 6'(DivNumW);
            end
            else
            begin
                rem_next = {2'b0, num[54:17]};
                num_next = {num[16:0], 38'd0};
                cnt_next = 6'(DivNarrowN);
            end
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[40])
            begin
                rem_next = diff[39:0];
                num_next = {num_reg[53:0], 1'b1};
            end
            else
            begin
                rem_next = trial[39:0];
                num_next = {num_reg[53:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;
endmodule
`default_nettype wire

### sv/sie_ctrl.sv
// Controller state machine for the EM step: sequences the datapath steps.
// Depends on sie_pkg.
`default_nettype none
module sie_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sie_pkg::sie_status_t status,
    output sie_pkg::sie_cmd_t      cmd
);
    import sie_pkg::*;

    logic [3:0] state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_PQ;
            ST_PQ:    state_next = ST_ADJ;
            ST_ADJ:   state_next = ST_QQ;
            ST_QQ:    state_next = ST_PP;
            ST_PP:    state_next = ST_PR1;
            ST_PR1:   state_next = ST_FLOOR;
            ST_FLOOR:
            begin
                sel_next   = 2'd0;
                state_next = status.mode ? ST_NDIV : ST_ACC;
            end
            ST_NDIV:  state_next = ST_NWAIT;
            ST_NWAIT:
            begin
                if (status.div_done)
                begin
                    state_next = (sel_reg == SEL_OBS) ? ST_ACC : ST_NMUL;
                end
            end
            ST_NMUL:
            begin
                if (sel_reg == 2'd2)
                begin
                    state_next = ST_PSUM;
                end
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = ST_NDIV;
                end
            end
            ST_PSUM:
            begin
                sel_next   = SEL_OBS;
                state_next = status.pp_zero ? ST_ACC : ST_NDIV;
            end
            ST_ACC:   state_next = status.last ? ST_FIN : ST_IDLE;
            ST_FIN:   state_next = status.exp_zero ? ST_OUT : ST_FWAIT;
            ST_FWAIT: if (status.div_done) state_next = ST_OUT;
            ST_OUT:   if (status.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    assign cmd.step   = state_reg;
    assign cmd.sel    = sel_reg;
    assign cmd.accept = accept;
endmodule
`default_nettype wire

### sv/sie_dp.sv
// Datapath for the EM step: sample registers, priors, posteriors,
// accumulators and output register. Depends on sie_pkg and sie_div.
`default_nettype none
module sie_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sie_pkg::sie_cmd_t  cmd,
    output sie_pkg::sie_status_t    status,
    input  wire logic               cfg_we,
    input  wire logic               cfg_wdata,
    input  wire logic [15:0]        allele_freq,
    input  wire logic [1:0]         genotype_code,
    input  wire logic [15:0]        lik_hom_ref,
    input  wire logic [15:0]        lik_het,
    input  wire logic signed [15:0] coef_old,
    input  wire logic               last_sample,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      coef_new,
    output logic signed [16:0]      coef_change,
    output logic                    missing_error
);
    import sie_pkg::*;

    logic        mode_reg;
    logic [15:0] p_reg;
    logic [16:0] q_reg;
    logic signed [15:0] f_reg;
    logic [1:0]  code_reg;
    logic [15:0] l0_reg, l1_reg;
    logic        last_reg;
    logic [14:0] pq_reg;
    logic signed [16:0] adj_reg;
    logic [16:0] a0_reg, a2_reg;
    logic signed [20:0] pr1raw_reg;
    logic [16:0] pri_reg [3];
    logic [18:0] sum_reg;
    logic [16:0] n_reg;
    logic [16:0] pp_reg [3];
    logic [18:0] s_reg;
    logic [16:0] obs_reg;
    logic [39:0] obs_acc_reg, exp_acc_reg;
    logic        err_reg;
    logic signed [15:0] fnew_reg;
    logic        out_valid_reg;
    logic signed [15:0] coef_new_reg;
    logic signed [16:0] coef_change_reg;
    logic        missing_reg;

    logic signed [31:0] adj_prod;
    logic signed [16:0] one_minus_f;
    logic signed [32:0] pr1_prod;
    logic signed [21:0] x0, x1, x2;
    logic [16:0] fl0, fl1, fl2;
    logic [16:0] l2;
    logic [16:0] lsel;
    logic [33:0] pp_prod;
    logic        div_start, div_wide, div_done;
    logic [54:0] div_num, div_quo;
    logic [39:0] div_den;
    logic [16:0] ratio;
    logic        skip;
    logic        load_out;

    // signed products
    assign adj_prod    = $signed({1'b0, pq_reg}) * f_reg;
    assign one_minus_f = 17'sd16384 - {f_reg[15], f_reg};
    assign pr1_prod    = $signed({1'b0, pq_reg}) * one_minus_f;

    // prior floor
    assign x0  = $signed({5'd0, a0_reg}) + {{5{adj_reg[16]}}, adj_reg};
    assign x1  = {pr1raw_reg[20], pr1raw_reg};
    assign x2  = $signed({5'd0, a2_reg}) + {{5{adj_reg[16]}}, adj_reg};
    assign fl0 = (x0 < $signed({5'd0, PRIOR_FLOOR})) ? PRIOR_FLOOR : x0[16:0];
    assign fl1 = (x1 < $signed({5'd0, PRIOR_FLOOR})) ? PRIOR_FLOOR : x1[16:0];
    assign fl2 = (x2 < $signed({5'd0, PRIOR_FLOOR})) ? PRIOR_FLOOR : x2[16:0];

    // third likelihood, clamped at zero
    assign l2 = ({1'b0, l0_reg} + {1'b0, l1_reg} >= PROB_ONE) ? 17'd0
              : 17'(PROB_ONE - {1'b0, l0_reg} - {1'b0, l1_reg});

    always_comb
    begin
        case (cmd.sel)
            2'd0:    lsel = {1'b0, l0_reg};
            2'd1:    lsel = {1'b0, l1_reg};
            default: lsel = l2;
        endcase
    end
    assign pp_prod = lsel * n_reg;

    // divider operands
    assign div_start = (cmd.step == ST_NDIV) || (cmd.step == ST_FIN && !status.exp_zero);
    assign div_wide  = (cmd.step == ST_FIN);
    always_comb
    begin
        if (div_wide)
        begin
            div_num = {1'b0, obs_acc_reg, 14'd0} + 55'(exp_acc_reg >> 1);
            div_den = exp_acc_reg;
        end
        else if (cmd.sel == SEL_OBS)
        begin
            div_num = 55'({pp_reg[1], 16'd0}) + 55'(s_reg >> 1);
            div_den = 40'(s_reg);
        end
        else
        begin
            div_num = 55'({pri_reg[cmd.sel], 16'd0}) + 55'(sum_reg >> 1);
            div_den = 40'(sum_reg);
        end
    end

    sie_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .wide  (div_wide),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign ratio    = (div_quo > 55'd32768) ? 17'd32768 : div_quo[16:0];
    assign skip     = !mode_reg && (code_reg == GT_MISSING);
    assign load_out = (cmd.step == ST_OUT) && status.out_free;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            p_reg    <= allele_freq;
            q_reg    <= PROB_ONE - {1'b0, allele_freq};
            f_reg    <= coef_old;
            code_reg <= genotype_code;
            l0_reg   <= lik_hom_ref;
            l1_reg   <= lik_het;
            last_reg <= last_sample;
        end
        case (cmd.step)
            ST_PQ:  pq_reg <= 15'(rnd16(34'(p_reg) * 34'(q_reg)));
            ST_ADJ: adj_reg <= 17'(rnd_s14({{2{adj_prod[31]}}, adj_prod}));
            ST_QQ:  a0_reg <= 17'(rnd16(34'(q_reg) * 34'(q_reg)));
            ST_PP:  a2_reg <= 17'(rnd16(34'(p_reg) * 34'(p_reg)));
            ST_PR1: pr1raw_reg <= rnd_s14({pr1_prod, 1'b0});
            ST_FLOOR:
            begin
                pri_reg[0] <= fl0;
                pri_reg[1] <= fl1;
                pri_reg[2] <= fl2;
                sum_reg    <= {2'b0, fl0} + {2'b0, fl1} + {2'b0, fl2};
                obs_reg    <= (code_reg == GT_HET) ? PROB_ONE : 17'd0;
            end
            ST_NWAIT:
            begin
                if (div_done)
                begin
                    if (cmd.sel == SEL_OBS)
                    begin
                        obs_reg <= div_quo[16:0];
                    end
                    else
                    begin
                        n_reg <= div_quo[16:0];
                    end
                end
            end
            ST_NMUL: pp_reg[cmd.sel] <= 17'(rnd16(pp_prod));
            ST_PSUM:
            begin
                s_reg   <= {2'b0, pp_reg[0]} + {2'b0, pp_reg[1]} + {2'b0, pp_reg[2]};
                obs_reg <= '0;
            end
            ST_FIN:   if (status.exp_zero) fnew_reg <= -16'sd16384;
            ST_FWAIT: if (div_done) fnew_reg <= 16'(17'sd16384 - $signed(ratio));
            default: ;
        endcase
        if (load_out)
        begin
            coef_new_reg    <= fnew_reg;
            coef_change_reg <= {fnew_reg[15], fnew_reg} - {f_reg[15], f_reg};
            missing_reg     <= err_reg;
        end
    end

    // control state: mode, accumulators, error flag, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            obs_acc_reg   <= '0;
            exp_acc_reg   <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (cmd.step == ST_ACC)
            begin
                if (skip)
                begin
                    err_reg <= 1'b1;
                end
                else
                begin
                    obs_acc_reg <= sat_add(obs_acc_reg, 40'(obs_reg));
                    exp_acc_reg <= sat_add(exp_acc_reg, 40'({pq_reg, 1'b0}));
                end
            end
            if (load_out)
            begin
                obs_acc_reg   <= '0;
                exp_acc_reg   <= '0;
                err_reg       <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.div_done = div_done;
    assign status.mode     = mode_reg;
    assign status.pp_zero  = (pp_reg[0] == '0) && (pp_reg[1] == '0) && (pp_reg[2] == '0);
    assign status.exp_zero = (exp_acc_reg == '0);
    assign status.last     = last_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign coef_new      = coef_new_reg;
    assign coef_change   = coef_change_reg;
    assign missing_error = missing_reg;
endmodule
`default_nettype wire

### sv/sie_checker.sv
// Port-level checker for the EM step top level, bound to it below.
// Depends on site_inbreeding_em_step_core_defines.svh.
`default_nettype none
`include "site_inbreeding_em_step_core_defines.svh"
module sie_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic signed [15:0] coef_new
);
    // a held result stays offered
    `SIE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    // one sample at a time
    `SIE_ASSERT_NEXT(a_one_sample, in_valid && in_ready, !in_ready)
    // coefficient always within [-1, 1]
    `SIE_ASSERT_NOW(a_coef_range, out_valid, coef_new >= -16'sd16384 && coef_new <= 16'sd16384)
    // a new result appears only in the cycle after a busy period
    `SIE_ASSERT_NOW(a_rise_busy, $rose(out_valid), !$past(in_ready))
endmodule

bind site_inbreeding_em_step_core sie_checker u_sie_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .coef_new  (results.coef_new)
);
`default_nettype wire
